// ===== sv/crc16fd_pkg.sv =====
// shared types, constants and crc function for the crc16 frame deframer
package crc16fd_pkg;

  // default payload store depth
  localparam int MAX_PAYLOAD_DEF = 32;

  // configuration register width and reset value
  localparam int              MAXLEN_W     = 6;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 6'd32;

  // header bytes
  localparam logic [7:0] HDR_FIRST  = 8'h5A;
  localparam logic [7:0] HDR_SECOND = 8'hA5;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_LEN_ERR = 2'd2;

  // crc-16/modbus: reflected poly, one byte per call
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // crc state after both header bytes
  localparam logic [15:0] HDR_CRC = crc_feed(crc_feed(CRC_INIT, HDR_FIRST), HDR_SECOND);

  // controller to datapath commands
  typedef struct packed {
    logic       crc_hdr;      // load crc with header value
    logic       take_type;    // hold type byte, feed crc
    logic       take_len;     // hold length byte, feed crc, clear count
    logic       store_data;   // write payload byte, feed crc, count up
    logic       take_crch;    // hold crc high byte
    logic       clear_count;  // reset byte counter before replay
    logic       rd_en;        // read payload store at counter
    logic       load_out;     // load output register
    logic       out_payload;  // output carries a replayed payload byte
    logic       count_inc;    // step the replay counter
    logic [1:0] out_status;   // status for the loaded result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_hdr1;      // rx byte is first header byte
    logic is_hdr2;      // rx byte is second header byte
    logic is_zero;      // rx byte is zero
    logic len_over;     // rx byte above the length limit
    logic data_done;    // this payload byte is the final one
    logic crc_ok;       // received crc matches
    logic len_zero;     // held length is zero
    logic replay_last;  // replay counter on the final byte
    logic out_free;     // output register can take a result this cycle
  } stat_t;

endpackage

// ===== sv/crc16fd_ram.sv =====
// generic single-port-write ram with registered read
module crc16fd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/crc16fd_dpath.sv =====
// deframer datapath: crc, held fields, byte counter, payload store, output register
module crc16fd_dpath #(
  parameter int MAX_PAYLOAD = crc16fd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  crc16fd_pkg::cmd_t                   cmd,
  output crc16fd_pkg::stat_t                  stat,
  input  logic                                cfg_valid,
  input  logic [crc16fd_pkg::MAXLEN_W-1:0]    cfg_data,
  input  logic [7:0]                          rx_byte,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [1:0]                          status,
  output logic [7:0]                          msg_type,
  output logic [7:0]                          payload_len,
  output logic [7:0]                          data_byte,
  output logic                                data_valid,
  output logic [4:0]                          byte_index,
  output logic                                last
);

  import crc16fd_pkg::*;

  localparam int         AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [6:0] MAX_P = 7'(MAX_PAYLOAD);

  logic [MAXLEN_W-1:0] max_len;
  logic [15:0]         crc_accum;
  logic [7:0]          held_type;
  logic [7:0]          held_length;
  logic [5:0]          byte_count;
  logic [7:0]          crc_high_rx;
  logic [7:0]          ram_rdata;
  logic [6:0]          limit;
  logic [7:0]          count_plus;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAXLEN_RESET;
    end else if (cfg_valid) begin
      max_len <= cfg_data;
    end
  end

  // limit in force is the smaller of register and store depth
  always_comb begin
    if ({1'b0, max_len} > MAX_P) begin
      limit = MAX_P;
    end else begin
      limit = {1'b0, max_len};
    end
  end

  assign count_plus = {2'b00, byte_count} + 8'd1;

  // status to controller
  always_comb begin
    stat.is_hdr1     = (rx_byte == HDR_FIRST);
    stat.is_hdr2     = (rx_byte == HDR_SECOND);
    stat.is_zero     = (rx_byte == 8'h00);
    stat.len_over    = (rx_byte > {1'b0, limit});
    stat.data_done   = (count_plus >= held_length);
    stat.crc_ok      = ({crc_high_rx, rx_byte} == crc_accum);
    stat.len_zero    = (held_length == 8'h00);
    stat.replay_last = (count_plus == held_length);
    stat.out_free    = !out_valid || !out_stall;
  end

  // crc accumulator, one byte per cycle while bytes are accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum <= CRC_INIT;
    end else if (cmd.crc_hdr) begin
      crc_accum <= HDR_CRC;
    end else if (cmd.take_type || cmd.take_len || cmd.store_data) begin
      crc_accum <= crc_feed(crc_accum, rx_byte);
    end
  end

  // held frame fields and byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      held_type   <= '0;
      held_length <= '0;
      byte_count  <= '0;
      crc_high_rx <= '0;
    end else begin
      if (cmd.take_type) begin
        held_type <= rx_byte;
      end
      if (cmd.take_len) begin
        held_length <= rx_byte;
      end
      if (cmd.take_crch) begin
        crc_high_rx <= rx_byte;
      end
      if (cmd.take_len || cmd.clear_count) begin
        byte_count <= '0;
      end else if (cmd.store_data || cmd.count_inc) begin
        byte_count <= count_plus[5:0];
      end
    end
  end

  // payload store
  crc16fd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store_data),
    .waddr (byte_count[AW-1:0]),
    .wdata (rx_byte),
    .re    (cmd.rd_en),
    .raddr (byte_count[AW-1:0]),
    .rdata (ram_rdata)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload; a length error reports the length byte taken this cycle
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status      <= cmd.out_status;
      msg_type    <= held_type;
      payload_len <= cmd.take_len ? rx_byte : held_length;
      if (cmd.out_payload) begin
        data_byte  <= ram_rdata;
        data_valid <= 1'b1;
        byte_index <= byte_count[4:0];
        last       <= stat.replay_last;
      end else begin
        data_byte  <= '0;
        data_valid <= 1'b0;
        byte_index <= '0;
        last       <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/crc16fd_ctrl.sv =====
// deframer controller: parse phases and payload replay sequencing
module crc16fd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  crc16fd_pkg::stat_t stat,
  output crc16fd_pkg::cmd_t  cmd
);

  import crc16fd_pkg::*;

  localparam logic [3:0] S_HUNT = 4'd0;
  localparam logic [3:0] S_HDR2 = 4'd1;
  localparam logic [3:0] S_TYPE = 4'd2;
  localparam logic [3:0] S_LEN  = 4'd3;
  localparam logic [3:0] S_DATA = 4'd4;
  localparam logic [3:0] S_CRCH = 4'd5;
  localparam logic [3:0] S_CRCL = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_LD   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;

  // stall during replay, and on result-producing bytes when output is blocked
  always_comb begin
    in_stall = (state == S_RD) || (state == S_LD) ||
               (((state == S_LEN) || (state == S_CRCL)) && !stat.out_free);
  end

  assign accept = in_valid && !in_stall;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.out_status = ST_OK;
    unique case (state)
      S_HUNT: begin
        if (accept && stat.is_hdr1) begin
          state_next = S_HDR2;
        end
      end
      S_HDR2: begin
        if (accept) begin
          if (stat.is_hdr2) begin
            cmd.crc_hdr = 1'b1;
            state_next  = S_TYPE;
          end else if (!stat.is_hdr1) begin
            state_next = S_HUNT;
          end
        end
      end
      S_TYPE: begin
        if (accept) begin
          cmd.take_type = 1'b1;
          state_next    = S_LEN;
        end
      end
      S_LEN: begin
        if (accept) begin
          cmd.take_len = 1'b1;
          if (stat.len_over) begin
            cmd.load_out   = 1'b1;
            cmd.out_status = ST_LEN_ERR;
            state_next     = S_HUNT;
          end else if (stat.is_zero) begin
            state_next = S_CRCH;
          end else begin
            state_next = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (accept) begin
          cmd.store_data = 1'b1;
          if (stat.data_done) begin
            state_next = S_CRCH;
          end
        end
      end
      S_CRCH: begin
        if (accept) begin
          cmd.take_crch = 1'b1;
          state_next    = S_CRCL;
        end
      end
      S_CRCL: begin
        if (accept) begin
          if (!stat.crc_ok) begin
            cmd.load_out   = 1'b1;
            cmd.out_status = ST_CRC_ERR;
            state_next     = S_HUNT;
          end else if (stat.len_zero) begin
            cmd.load_out   = 1'b1;
            cmd.out_status = ST_OK;
            state_next     = S_HUNT;
          end else begin
            cmd.clear_count = 1'b1;
            state_next      = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LD;
      end
      S_LD: begin
        if (stat.out_free) begin
          cmd.load_out    = 1'b1;
          cmd.out_payload = 1'b1;
          cmd.out_status  = ST_OK;
          cmd.count_inc   = 1'b1;
          if (stat.replay_last) begin
            state_next = S_HUNT;
          end else begin
            state_next = S_RD;
          end
        end
      end
      default: begin
        state_next = S_HUNT;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/crc16_frame_deframer_core.sv =====
// crc16 frame deframer top level: controller plus datapath
//
// Input channel: one received serial byte per request on rx_byte, taken at a
// clock edge with in_valid high and in_stall low. Bytes are parsed as header
// 0x5A 0xA5, type, length, payload, crc high, crc low (crc-16/modbus).
// Output channel: one result per request (status, msg_type, payload_len,
// data_byte, data_valid, byte_index, last), taken when out_valid is high and
// out_stall is low. A held result stays put while out_stall is high.
// Configuration: max_payload_len is written on cfg_valid; cfg_ready is always
// high. Write it only while no frame is in flight.
// Throughput: one byte per cycle while parsing. An error or empty-frame result
// appears the cycle after the length or crc low byte. A good frame replays its
// payload one byte at a time, each by a store read and then an output load that
// waits while a held result is stalled; input is stalled during replay, and also
// on length and crc low bytes while a result waits to be taken.
// Reset: parser returns to header hunt, the output register empties and the
// length limit returns to 32. The payload store needs no clearing.
module crc16_frame_deframer_core #(
  parameter int MAX_PAYLOAD = crc16fd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic [7:0]                       msg_type,
  output logic [7:0]                       payload_len,
  output logic [7:0]                       data_byte,
  output logic                             data_valid,
  output logic [4:0]                       byte_index,
  output logic                             last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crc16fd_pkg::MAXLEN_W-1:0] max_payload_len
);

  import crc16fd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  crc16fd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  crc16fd_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_data    (max_payload_len),
    .rx_byte     (rx_byte),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .status      (status),
    .msg_type    (msg_type),
    .payload_len (payload_len),
    .data_byte   (data_byte),
    .data_valid  (data_valid),
    .byte_index  (byte_index),
    .last        (last)
  );

endmodule

// ===== verif/tb_crc16_frame_deframer_core.sv =====
// self-checking testbench for the crc16 frame deframer core
`timescale 1ns / 100ps

import crc16fd_pkg::*;

// parser position of the frame predictor
typedef enum logic [2:0] {
  PH_HUNT,
  PH_HDR2,
  PH_TYPE,
  PH_LEN,
  PH_DATA,
  PH_CRC_HI,
  PH_CRC_LO
} parse_phase_e;

// one deframer result as seen on the output channel
typedef struct packed {
  logic [1:0] status;
  logic [7:0] ftype;
  logic [7:0] plen;
  logic [7:0] data;
  logic       dvalid;
  logic [4:0] idx;
  logic       last;
} frame_result_t;

// defects put into generated frames
typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_DATA, FLAW_CUT} flaw_e;

// frame predictor and result checker
class frame_scoreboard;
  frame_result_t           awaited[$];
  logic [MAXLEN_W-1:0]     max_len;
  parse_phase_e            phase;
  logic [15:0]             crc_acc;
  logic [7:0]              held_type;
  logic [7:0]              held_len;
  logic [5:0]              count;
  logic [7:0]              crc_hi;
  logic [7:0]              payload[MAX_PAYLOAD_DEF];
  int                      mismatches;
  int                      checked;
  int                      good_frames;
  int                      crc_errs;
  int                      len_errs;

  function new();
    max_len     = MAXLEN_RESET;
    phase       = PH_HUNT;
    crc_acc     = CRC_INIT;
    held_type   = '0;
    held_len    = '0;
    count       = '0;
    crc_hi      = '0;
    mismatches  = 0;
    checked     = 0;
    good_frames = 0;
    crc_errs    = 0;
    len_errs    = 0;
  endfunction

  // bitwise crc-16/modbus, lsb first
  static function logic [15:0] modbus_crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[15:1]};
      if (fb) begin
        c = c ^ 16'hA001;
      end
    end
    return c;
  endfunction

  function int active_limit();
    return (int'(max_len) > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : int'(max_len);
  endfunction

  function void push_result(input logic [1:0] st, input logic [7:0] data, input logic dvalid,
                            input logic [4:0] idx, input logic last);
    frame_result_t r;
    r.status = st;
    r.ftype  = held_type;
    r.plen   = held_len;
    r.data   = data;
    r.dvalid = dvalid;
    r.idx    = idx;
    r.last   = last;
    awaited.push_back(r);
  endfunction

  // advance the parser by one accepted byte and queue the results it causes
  function void note_rx_byte(input logic [7:0] b);
    case (phase)
      PH_HUNT: begin
        if (b == HDR_FIRST) phase = PH_HDR2;
      end
      PH_HDR2: begin
        if (b == HDR_SECOND) begin
          crc_acc = modbus_crc_step(modbus_crc_step(CRC_INIT, HDR_FIRST), HDR_SECOND);
          phase   = PH_TYPE;
        end else if (b != HDR_FIRST) begin
          phase = PH_HUNT;
        end
      end
      PH_TYPE: begin
        held_type = b;
        crc_acc   = modbus_crc_step(crc_acc, b);
        phase     = PH_LEN;
      end
      PH_LEN: begin
        held_len = b;
        crc_acc  = modbus_crc_step(crc_acc, b);
        count    = '0;
        if (int'(b) > active_limit()) begin
          push_result(ST_LEN_ERR, 8'h00, 1'b0, 5'd0, 1'b1);
          len_errs++;
          phase = PH_HUNT;
        end else if (b == 8'h00) begin
          phase = PH_CRC_HI;
        end else begin
          phase = PH_DATA;
        end
      end
      PH_DATA: begin
        if (int'(count) < MAX_PAYLOAD_DEF) payload[count] = b;
        crc_acc = modbus_crc_step(crc_acc, b);
        count   = count + 6'd1;
        if (8'(count) >= held_len) phase = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        crc_hi = b;
        phase  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        if ({crc_hi, b} != crc_acc) begin
          push_result(ST_CRC_ERR, 8'h00, 1'b0, 5'd0, 1'b1);
          crc_errs++;
        end else if (held_len == 8'h00) begin
          push_result(ST_OK, 8'h00, 1'b0, 5'd0, 1'b1);
          good_frames++;
        end else begin
          for (int k = 0; k < int'(held_len) && k < MAX_PAYLOAD_DEF; k++) begin
            push_result(ST_OK, payload[k], 1'b1, 5'(k), (k + 1 == int'(held_len)));
          end
          good_frames++;
        end
        phase = PH_HUNT;
      end
      default: phase = PH_HUNT;
    endcase
  endfunction

  task report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // compare one accepted result with the oldest expectation
  task check_result(input frame_result_t got);
    frame_result_t want;
    string         bad;
    checked++;
    if (awaited.size() == 0) begin
      report_mismatch($sformatf("unexpected result st=%0d type=%h len=%h data=%h v=%b idx=%0d last=%b",
                      got.status, got.ftype, got.plen, got.data, got.dvalid, got.idx, got.last));
    end else begin
      want = awaited.pop_front();
      bad  = "";
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.ftype  !== want.ftype)  bad = {bad, " msg_type"};
      if (got.plen   !== want.plen)   bad = {bad, " payload_len"};
      if (got.data   !== want.data)   bad = {bad, " data_byte"};
      if (got.dvalid !== want.dvalid) bad = {bad, " data_valid"};
      if (got.idx    !== want.idx)    bad = {bad, " byte_index"};
      if (got.last   !== want.last)   bad = {bad, " last"};
      if (bad != "") begin
        report_mismatch($sformatf({"wrong%s: got st=%0d type=%h len=%h data=%h v=%b idx=%0d",
                        " last=%b, want st=%0d type=%h len=%h data=%h v=%b idx=%0d last=%b"},
                        bad, got.status, got.ftype, got.plen, got.data, got.dvalid, got.idx,
                        got.last, want.status, want.ftype, want.plen, want.data, want.dvalid,
                        want.idx, want.last));
      end
    end
  endtask
endclass

module tb_crc16_frame_deframer_core;

  localparam int CYCLE_LIMIT = 400000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [7:0]          rx_byte;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          status;
  logic [7:0]          msg_type;
  logic [7:0]          payload_len;
  logic [7:0]          data_byte;
  logic                data_valid;
  logic [4:0]          byte_index;
  logic                last;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [MAXLEN_W-1:0] max_payload_len;

  frame_scoreboard sb;
  bit              calm;
  int              bytes_sent;
  int              cycle_count;
  int              stall_left;
  int              mid_limit;

  crc16_frame_deframer_core i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .msg_type        (msg_type),
    .payload_len     (payload_len),
    .data_byte       (data_byte),
    .data_valid      (data_valid),
    .byte_index      (byte_index),
    .last            (last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .max_payload_len (max_payload_len)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("crc16_frame_deframer_core regression: fail");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // monitor: config writes, accepted bytes, then accepted results
  always @(posedge clk) begin
    frame_result_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.max_len = max_payload_len;
      if (in_valid && !in_stall) sb.note_rx_byte(rx_byte);
      if (out_valid && !out_stall) begin
        got.status = status;
        got.ftype  = msg_type;
        got.plen   = payload_len;
        got.data   = data_byte;
        got.dvalid = data_valid;
        got.idx    = byte_index;
        got.last   = last;
        sb.check_result(got);
      end
    end
  end

  // one byte request, held until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // stop sending until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
  endtask

  // feed zeros until the parser is back to header hunt
  task automatic flush_parser();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.phase != PH_HUNT) begin
      send_byte(8'h00);
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_limit(input logic [MAXLEN_W-1:0] v);
    cfg_valid       <= 1'b1;
    max_payload_len <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // build a frame with a good crc, optionally damage it, and send it
  task automatic send_frame(input logic [7:0] ftype, input int len, input flaw_e flaw);
    logic [7:0]  fb[$];
    logic [15:0] acc;
    int          pos;
    int          cut;
    fb.push_back(HDR_FIRST);
    fb.push_back(HDR_SECOND);
    fb.push_back(ftype);
    fb.push_back(8'(len));
    // over-length frames end at the length byte
    if (len <= sb.active_limit()) begin
      for (int i = 0; i < len; i++) fb.push_back(8'($urandom_range(0, 255)));
      acc = CRC_INIT;
      foreach (fb[i]) acc = sb.modbus_crc_step(acc, fb[i]);
      fb.push_back(acc[15:8]);
      fb.push_back(acc[7:0]);
      case (flaw)
        FLAW_CRC: begin
          pos     = fb.size() - 1 - $urandom_range(0, 1);
          fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        FLAW_DATA: begin
          pos     = (len > 0) ? 4 + $urandom_range(0, len - 1) : fb.size() - 1;
          fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        FLAW_CUT: begin
          cut = $urandom_range(1, fb.size() - 3);
          repeat (cut) void'(fb.pop_back());
        end
        default: ;
      endcase
    end
    foreach (fb[i]) send_byte(fb[i]);
  endtask

  // random frames, noise and broken frames at the current limit
  task automatic run_random(input int target);
    int    start_count;
    int    lim;
    int    len;
    int    r;
    int    n;
    flaw_e flaw;
    start_count = bytes_sent;
    while (bytes_sent - start_count < target) begin
      calm = ($urandom_range(0, 5) == 0);
      lim  = sb.active_limit();
      r    = $urandom_range(0, 99);
      if (r < 8) begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60)      len = $urandom_range(0, (lim < 8) ? lim : 8);
        else if (r < 80) len = $urandom_range(0, lim);
        else if (r < 88) len = lim;
        else             len = $urandom_range(lim + 1, 255);
        r = $urandom_range(0, 99);
        flaw = (r < 75) ? FLAW_NONE : (r < 85) ? FLAW_CRC : (r < 92) ? FLAW_DATA : FLAW_CUT;
        send_frame(8'($urandom_range(0, 255)), len, flaw);
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end
    calm = 1'b0;
    flush_parser();
    wait_drained();
    // let any result still in flight come out before the next setting
    repeat (12) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int waited;
    sb              = new();
    calm            = 1'b0;
    bytes_sent      = 0;
    cycle_count     = 0;
    rst             <= 1'b1;
    in_valid        <= 1'b0;
    rx_byte         <= 8'h00;
    cfg_valid       <= 1'b0;
    max_payload_len <= MAXLEN_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: noise, header resync with empty frame, broken header,
    // length over limit, crc mismatch
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_FIRST);
    send_frame(8'hFF, 0, FLAW_NONE);
    send_byte(HDR_FIRST);
    send_byte(8'h13);
    send_frame(8'h00, 33, FLAW_NONE);
    send_frame(8'h80, 1, FLAW_CRC);
    wait_drained();

    run_random(70);
    write_limit('0);
    run_random(40);
    write_limit('1);
    run_random(80);
    mid_limit = $urandom_range(1, 31);
    write_limit(MAXLEN_W'(mid_limit));
    run_random(70);
    write_limit(MAXLEN_RESET);
    run_random(70);

    // final drain with a bound of its own
    in_valid <= 1'b0;
    waited = 0;
    while (sb.awaited.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.awaited.size() != 0)
      sb.report_mismatch($sformatf("%0d expected results never came", sb.awaited.size()));
    repeat (20) @(posedge clk);

    $display("sent %0d bytes, checked %0d results: %0d good frames, %0d crc errors, %0d length errors",
             bytes_sent, sb.checked, sb.good_frames, sb.crc_errs, sb.len_errs);
    $display("length limits used: 32, 0, 63, %0d, 32; random gaps and stalls on both channels",
             mid_limit);
    if (sb.mismatches == 0)
      $display("crc16_frame_deframer_core regression: pass");
    else
      $display("crc16_frame_deframer_core regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/crc16fd_pkg.sv
sv/crc16fd_ram.sv
sv/crc16fd_dpath.sv
sv/crc16fd_ctrl.sv
sv/crc16_frame_deframer_core.sv
verif/tb_crc16_frame_deframer_core.sv
